// ----- src/greedy_dirty_rect_merger_assert.svh -----
// ----------------------------------------------------------------------------
// greedy_dirty_rect_merger_assert.svh
// Assertion macros shared by the checker of the dirty-rectangle merger.
// ----------------------------------------------------------------------------
`ifndef GREEDY_DIRTY_RECT_MERGER_ASSERT_SVH
`define GREEDY_DIRTY_RECT_MERGER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GRM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- src/grm_pkg.sv -----
// ----------------------------------------------------------------------------
// grm_pkg
// Types and constants of the greedy dirty-rectangle merger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package grm_pkg;

    localparam int MAX_REGIONS  = 16;
    localparam int COORD_BITS   = 12;
    localparam int IDX_W        = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W        = $clog2(MAX_REGIONS + 1);
    localparam int AREA_W       = 2 * COORD_BITS;
    localparam int COST_W       = 24;
    localparam int THR_W        = ((AREA_W > COST_W) ? AREA_W : COST_W) + 1;
    localparam logic [31:0] GROWTH_LIMIT = 32'd10000000;
    localparam logic [COST_W-1:0] COST_RESET = COST_W'(1000);

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [AREA_W-1:0]     area_t;

    typedef struct packed {
        coord_t l;
        coord_t t;
        coord_t r;
        coord_t b;
    } box_t;

    typedef struct packed {
        logic   kind;
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
    } grm_in_t;

    typedef struct packed {
        coord_t out_left;
        coord_t out_top;
        coord_t out_right;
        coord_t out_bottom;
        logic   last;
    } grm_out_t;

    // Tag that travels with each table read
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } grm_tag_t;

endpackage

`default_nettype wire

// ----- src/greedy_dirty_rect_merger.sv -----
// ----------------------------------------------------------------------------
// greedy_dirty_rect_merger
// Keeps a table of dirty rectangles, merges each new one greedily into the
// entry it grows least unless a new entry is cheaper and fits; emits on flush.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the item is finished. The table sits in one synchronous RAM with a
// single read port, so an add scans it one entry per cycle, and the scan is
// followed by the read register, the two growth stages, the final drain check
// and the decide and write-back. An add gives no result. With n entries in
// the table a flush puts the n entries out in table order on back-to-back
// cycles, one beat per cycle marked by result_valid, with last set on the
// final beat; the receiver cannot stall and must take every beat. A flush of
// an empty table gives no beat. new_region_cost is written through
// cfg_we/cfg_wdata; the user must do so only while busy is low, as the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_dirty_rect_merger (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire grm_pkg::grm_in_t             in_item,
    output logic                              busy,
    output logic                              result_valid,
    output grm_pkg::grm_out_t                 result,
    input  wire logic                         cfg_we,
    input  wire logic [grm_pkg::COST_W-1:0]   cfg_wdata
);
    import grm_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_FLUSH  = 2'd3;

    // Region table: one write port, one registered read port
    box_t             table_mem [MAX_REGIONS];
    box_t             mem_rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    box_t             mem_wdata;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             issue;
    grm_tag_t         rd_tag_reg;
    logic [COST_W-1:0] cost_reg;

    // New rectangle and its area
    box_t             nb_reg;
    box_t             nb_next;
    area_t            nb_area_reg;
    coord_t           nb_w;
    coord_t           nb_h;

    // Best candidate so far
    logic             have_reg;
    logic [IDX_W-1:0] best_idx_reg;
    area_t            best_g_reg;
    box_t             best_uni_reg;

    grm_tag_t         g_tag_in;
    grm_tag_t         g_tag;
    area_t            g_growth;
    box_t             g_uni;
    logic             g_busy;

    logic [THR_W-1:0] thr;
    logic             merge_ok;
    logic             accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // Normalize reversed edges to an empty box
    always_comb
    begin
        nb_next.l = in_item.left;
        nb_next.t = in_item.top;
        nb_next.r = (in_item.right < in_item.left) ? in_item.left : in_item.right;
        nb_next.b = (in_item.bottom < in_item.top) ? in_item.top : in_item.bottom;
    end

    assign nb_w = (nb_reg.r > nb_reg.l) ? coord_t'(nb_reg.r - nb_reg.l) : '0;
    assign nb_h = (nb_reg.b > nb_reg.t) ? coord_t'(nb_reg.b - nb_reg.t) : '0;

    // Merge when growth is under the ceiling and cheaper than a new region
    assign thr      = THR_W'(nb_area_reg) + THR_W'(cost_reg);
    assign merge_ok = have_reg && (32'(best_g_reg) < GROWTH_LIMIT)
                      && (THR_W'(best_g_reg) < thr);

    // Only scan reads feed the growth pipe
    always_comb
    begin
        g_tag_in       = rd_tag_reg;
        g_tag_in.valid = rd_tag_reg.valid && (state_reg == S_SCAN);
    end

    grm_growth u_growth (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (g_tag_in),
        .stored    (mem_rdata_reg),
        .nb        (nb_reg),
        .tag_out   (g_tag),
        .growth    (g_growth),
        .uni       (g_uni),
        .pipe_busy (g_busy)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        issue      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = best_idx_reg;
        mem_wdata  = best_uni_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    state_next = (in_item.kind == KIND_FLUSH) ? S_FLUSH : S_SCAN;
                end
            end
            S_SCAN, S_FLUSH:
            begin
                if (idx_reg < count_reg)
                begin
                    // Advance the read pointer one entry per cycle
                    issue    = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                end
                else if (!rd_tag_reg.valid && !g_busy)
                begin
                    if (state_reg == S_SCAN)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        // Drop the whole table once the last beat is out
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            S_DECIDE:
            begin
                mem_we = 1'b1;
                if (!merge_ok && (count_reg != CNT_W'(MAX_REGIONS)))
                begin
                    // Append as a new region
                    mem_waddr  = count_reg[IDX_W-1:0];
                    mem_wdata  = nb_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            count_reg  <= '0;
            rd_tag_reg <= '0;
            cost_reg   <= COST_RESET;
            have_reg   <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            count_reg        <= count_next;
            rd_tag_reg.valid <= issue;
            rd_tag_reg.last  <= ((idx_reg + CNT_W'(1)) == count_reg);
            rd_tag_reg.idx   <= idx_reg[IDX_W-1:0];
            if (cfg_we)
            begin
                cost_reg <= cfg_wdata;
            end
            if (accept)
            begin
                have_reg <= 1'b0;
            end
            else if (g_tag.valid)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nb_reg <= nb_next;
        end
        nb_area_reg <= area_t'(nb_w) * area_t'(nb_h);
        // First entry wins a tie: replace only on strictly smaller growth
        if (g_tag.valid && (!have_reg || (g_growth < best_g_reg)))
        begin
            best_idx_reg <= g_tag.idx;
            best_g_reg   <= g_growth;
            best_uni_reg <= g_uni;
        end
    end

    // Region table storage
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= table_mem[idx_reg[IDX_W-1:0]];
    end

    // Flush beats come straight from the read register
    assign result_valid      = rd_tag_reg.valid && (state_reg == S_FLUSH);
    assign result.out_left   = mem_rdata_reg.l;
    assign result.out_top    = mem_rdata_reg.t;
    assign result.out_right  = mem_rdata_reg.r;
    assign result.out_bottom = mem_rdata_reg.b;
    assign result.last       = rd_tag_reg.last;

endmodule

`default_nettype wire

// ----- src/grm_growth.sv -----
// ----------------------------------------------------------------------------
// grm_growth
// Two-stage pipe: union box of a stored entry with the new box, then the
// areas, giving the growth of the entry's area.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grm_growth (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire grm_pkg::grm_tag_t tag_in,
    input  wire grm_pkg::box_t     stored,
    input  wire grm_pkg::box_t     nb,
    output grm_pkg::grm_tag_t      tag_out,
    output grm_pkg::area_t         growth,
    output grm_pkg::box_t          uni,
    output logic                   pipe_busy
);
    import grm_pkg::*;

    logic     s_empty;
    logic     n_empty;
    box_t     u_next;
    coord_t   uw_next;
    coord_t   uh_next;
    coord_t   sw_next;
    coord_t   sh_next;

    grm_tag_t s1_tag_reg;
    box_t     s1_uni_reg;
    coord_t   s1_uw_reg;
    coord_t   s1_uh_reg;
    coord_t   s1_sw_reg;
    coord_t   s1_sh_reg;

    grm_tag_t s2_tag_reg;
    box_t     s2_uni_reg;
    area_t    s2_ua_reg;
    area_t    s2_sa_reg;

    always_comb
    begin
        s_empty = (stored.r <= stored.l) || (stored.b <= stored.t);
        n_empty = (nb.r <= nb.l) || (nb.b <= nb.t);
        if (s_empty)
        begin
            u_next = nb;
        end
        else if (n_empty)
        begin
            u_next = stored;
        end
        else
        begin
            u_next.l = (stored.l < nb.l) ? stored.l : nb.l;
            u_next.t = (stored.t < nb.t) ? stored.t : nb.t;
            u_next.r = (stored.r > nb.r) ? stored.r : nb.r;
            u_next.b = (stored.b > nb.b) ? stored.b : nb.b;
        end
        uw_next = (u_next.r > u_next.l) ? coord_t'(u_next.r - u_next.l) : '0;
        uh_next = (u_next.b > u_next.t) ? coord_t'(u_next.b - u_next.t) : '0;
        sw_next = (stored.r > stored.l) ? coord_t'(stored.r - stored.l) : '0;
        sh_next = (stored.b > stored.t) ? coord_t'(stored.b - stored.t) : '0;
    end

    // Tags carry control and are reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= tag_in;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_uni_reg <= u_next;
        s1_uw_reg  <= uw_next;
        s1_uh_reg  <= uh_next;
        s1_sw_reg  <= sw_next;
        s1_sh_reg  <= sh_next;
        s2_uni_reg <= s1_uni_reg;
        s2_ua_reg  <= area_t'(s1_uw_reg) * area_t'(s1_uh_reg);
        s2_sa_reg  <= area_t'(s1_sw_reg) * area_t'(s1_sh_reg);
    end

    assign tag_out   = s2_tag_reg;
    assign uni       = s2_uni_reg;
    assign growth    = (s2_ua_reg > s2_sa_reg) ? area_t'(s2_ua_reg - s2_sa_reg) : '0;
    assign pipe_busy = s1_tag_reg.valid || s2_tag_reg.valid;

endmodule

`default_nettype wire

// ----- src/grm_checker.sv -----
// ----------------------------------------------------------------------------
// grm_checker
// Port-level checks on the dirty-rectangle merger, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "greedy_dirty_rect_merger_assert.svh"

module grm_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic              result_valid,
    input  wire grm_pkg::grm_out_t result
);
    import grm_pkg::*;

    // Beats only come out while a flush is in progress
    `GRM_ASSERT_IMPLY(a_beat_while_busy, result_valid, busy)
    // A taken item holds the block busy in the next cycle
    `GRM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // Nothing follows the last beat of a flush
    `GRM_ASSERT_NEXT(a_last_ends, result_valid && result.last, !result_valid)
    // Beats of one flush run back to back
    `GRM_ASSERT_NEXT(a_beats_contiguous, result_valid && !result.last, result_valid)

endmodule

bind greedy_dirty_rect_merger grm_checker u_grm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire
